// File: rtl/core/fvc_pkg.sv
package fvc_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned COLOR_BITS = 8;
  localparam int unsigned LOG_TABLE_BITS = 8;
  localparam int unsigned LOG_TBL_SIZE = 1 << LOG_TABLE_BITS;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LOG_BITS = 22;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [FRAC_BITS:0] FRAC_ONE = 17'h10000;
  localparam logic [FRAC_BITS:0] FRAC_HALF = 17'h08000;

  localparam int unsigned SQRT_STAGES = 8;
  localparam int unsigned SQRT_STEPS = 4;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS = 4;

  localparam logic [31:0] RECIP_10K = 32'd3518437209;
  localparam int unsigned RECIP_10K_SHIFT = 45;
  localparam logic [31:0] RECIP_100K = 32'd2814749768;
  localparam int unsigned RECIP_100K_SHIFT = 48;
  localparam logic [20:0] RECIP_1K = 21'd1073742;
  localparam int unsigned RECIP_1K_SHIFT = 30;
  localparam logic [37:0] CODE_ROUND = 38'd32768000;
  localparam logic [COLOR_BITS-1:0] CODE_MAX = {COLOR_BITS{1'b1}};

  localparam logic signed [VALUE_BITS-1:0] RANGE_HIGH_RST = 32'sd65536;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_QUANTITY_SELECT = 3'd0,
    CFG_DIVERGING_MODE  = 3'd1,
    CFG_LOG_SCALE       = 3'd2,
    CFG_RANGE_LOW       = 3'd3,
    CFG_RANGE_HIGH      = 3'd4
  } fvc_cfg_idx_e;

  typedef enum logic [1:0] {
    QTY_X   = 2'd0,
    QTY_Y   = 2'd1,
    QTY_Z   = 2'd2,
    QTY_MAG = 2'd3
  } fvc_qty_e;

  typedef enum logic [2:0] {
    KIND_ZERO = 3'd0,
    KIND_ONE  = 3'd1,
    KIND_HALF = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_LOG  = 3'd4
  } fvc_kind_e;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] field_x;
    logic signed [VALUE_BITS-1:0] field_y;
    logic signed [VALUE_BITS-1:0] field_z;
  } fvc_in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } fvc_out_t;

  typedef struct packed {
    logic               mag;
    logic               k;
    logic signed [33:0] comp;
  } fvc_sq_side_t;

  typedef struct packed {
    fvc_kind_e kind;
    logic      neg;
  } fvc_div_side_t;

  typedef logic [9:0] milli_t;
  typedef logic [FRAC_BITS-1:0] log_tbl_t [LOG_TBL_SIZE];

  localparam milli_t VIRIDIS [6][3] = '{
    '{10'd267, 10'd5,   10'd329},
    '{10'd283, 10'd141, 10'd458},
    '{10'd254, 10'd265, 10'd530},
    '{10'd164, 10'd471, 10'd558},
    '{10'd478, 10'd821, 10'd318},
    '{10'd993, 10'd906, 10'd144}
  };
  localparam milli_t DIV_BLUE [3] = '{10'd160, 10'd360, 10'd720};
  localparam milli_t DIV_WHITE [3] = '{10'd960, 10'd960, 10'd960};
  localparam milli_t DIV_RED [3] = '{10'd790, 10'd160, 10'd160};

  function automatic log_tbl_t gen_log_tbl();
    log_tbl_t tbl;
    logic [63:0] m;
    logic [FRAC_BITS-1:0] f;
    for (int i = 0; i < LOG_TBL_SIZE; i++) begin
      m = 64'(LOG_TBL_SIZE + i) << (30 - LOG_TABLE_BITS);
      f = '0;
      for (int j = 0; j < FRAC_BITS; j++) begin
        m = (m * m) >> 30;
        f = {f[FRAC_BITS-2:0], 1'b0};
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          f[0] = 1'b1;
        end
      end
      tbl[i] = f;
    end
    return tbl;
  endfunction

  localparam log_tbl_t LOG_TBL = gen_log_tbl();

  function automatic logic [5:0] lead_one(input logic [33:0] x);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 34; i++) begin
      if (x[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [LOG_TABLE_BITS-1:0] log_idx(input logic [33:0] x,
                                                        input logic [5:0] msb);
    logic [33:0] sh;
    if (msb >= 6'(LOG_TABLE_BITS)) begin
      sh = x >> (msb - 6'(LOG_TABLE_BITS));
    end else begin
      sh = x << (6'(LOG_TABLE_BITS) - msb);
    end
    return sh[LOG_TABLE_BITS-1:0];
  endfunction

  function automatic logic [LOG_BITS-1:0] log2q(input logic [33:0] x);
    logic [5:0] msb;
    logic [LOG_TABLE_BITS-1:0] idx;
    msb = lead_one(x);
    idx = log_idx(x, msb);
    return {msb, {FRAC_BITS{1'b0}}} + LOG_BITS'(LOG_TBL[idx]);
  endfunction

endpackage

// File: rtl/core/fvc_isqrt.sv
module fvc_isqrt
  import fvc_pkg::*;
(
  input  logic                   clk_i,
  input  logic [SQRT_STAGES-1:0] en_i,
  input  logic [63:0]            rad_i,
  input  fvc_sq_side_t           side_i,
  output logic [31:0]            root_o,
  output fvc_sq_side_t           side_o
);

  logic [35:0]  rem_q  [SQRT_STAGES];
  logic [31:0]  root_q [SQRT_STAGES];
  logic [63:0]  rad_q  [SQRT_STAGES];
  fvc_sq_side_t side_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [35:0]  rem_in, rem_d, trial;
    logic [31:0]  root_in, root_d;
    logic [63:0]  rad_in, rad_d;
    fvc_sq_side_t side_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      rem_d  = rem_in;
      root_d = root_in;
      rad_d  = rad_in;
      trial  = '0;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem_d = {rem_d[33:0], rad_d[63:62]};
        rad_d = {rad_d[61:0], 2'b00};
        trial = {2'b00, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[30:0], 1'b1};
        end else begin
          root_d = {root_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        rad_q[s]  <= rad_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];
  assign side_o = side_q[SQRT_STAGES-1];

endmodule

// File: rtl/core/fvc_div.sv
module fvc_div
  import fvc_pkg::*;
(
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [33:0]           num_i,
  input  logic [33:0]           den_i,
  input  fvc_div_side_t         side_i,
  output logic [FRAC_BITS-1:0]  quot_o,
  output fvc_div_side_t         side_o
);

  logic [33:0]          rem_q  [DIV_STAGES];
  logic [33:0]          den_q  [DIV_STAGES];
  logic [FRAC_BITS-1:0] quot_q [DIV_STAGES];
  fvc_div_side_t        side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [34:0]          rem_w;
    logic [33:0]          rem_in, den_in;
    logic [FRAC_BITS-1:0] quot_in, quot_d;
    fvc_div_side_t        side_in;

    if (s == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quot_in = quot_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      rem_w  = {1'b0, rem_in};
      quot_d = quot_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_w = {rem_w[33:0], 1'b0};
        if (rem_w >= {1'b0, den_in}) begin
          rem_w  = rem_w - {1'b0, den_in};
          quot_d = {quot_d[FRAC_BITS-2:0], 1'b1};
        end else begin
          quot_d = {quot_d[FRAC_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_w[33:0];
        den_q[s]  <= den_in;
        quot_q[s] <= quot_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign quot_o = quot_q[DIV_STAGES-1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule

// File: rtl/core/field_value_colormap.sv
// Maps one field vector sample to one RGB color per request.
// Input channel: in_valid_i, in_stall_o and in_data_i carry x, y and z in
// signed Q16.16. A request is taken at a clock edge with in_valid_i high and
// in_stall_o low. Output channel: out_valid_o, out_stall_i and out_data_o
// carry 8-bit red, green and blue codes.
// The pipeline has 25 register stages, from the input register to the output
// register that drives out_valid_o. One request can enter every cycle while
// in_stall_o is low, so throughput is one color per clock. The pipeline holds
// the 32-step square root (eight stages of four steps) and the 16-step
// fraction divider (four stages of four steps).
// When the receiver stalls, the output register holds and the stages behind
// it keep filling any empty slots; in_stall_o rises only once every stage
// holds a request.
// Configuration writes on cfg_valid_i, cfg_index_i and cfg_data_i are always
// ready and must be made while no request is in flight. Derived range values
// are registered and settle after a write.
// Reset empties the pipeline and loads magnitude, linear scale, viridis ramp
// and a range of 0 to 1.0.
module field_value_colormap
  import fvc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  fvc_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output fvc_out_t                out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [VALUE_BITS-1:0]   cfg_data_i
);

  localparam int unsigned SQ_LO = 4;
  localparam int unsigned SQ_HI = SQ_LO + SQRT_STAGES - 1;
  localparam int unsigned V_ST = SQ_HI + 1;
  localparam int unsigned PREP_ST = V_ST + 1;
  localparam int unsigned LZ_ST = PREP_ST + 1;
  localparam int unsigned LG_ST = LZ_ST + 1;
  localparam int unsigned DV_LO = LG_ST + 1;
  localparam int unsigned DV_HI = DV_LO + DIV_STAGES - 1;
  localparam int unsigned T_ST = DV_HI + 1;
  localparam int unsigned C1_ST = T_ST + 1;
  localparam int unsigned C2_ST = C1_ST + 1;
  localparam int unsigned C3_ST = C2_ST + 1;
  localparam int unsigned OUT_ST = C3_ST + 1;
  localparam int unsigned NS = OUT_ST + 1;

  fvc_qty_e                      quantity_select_q;
  logic                          diverging_mode_q;
  logic                          log_scale_q;
  logic signed [VALUE_BITS-1:0]  range_low_q;
  logic signed [VALUE_BITS-1:0]  range_high_q;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantity_select_q <= QTY_MAG;
      diverging_mode_q  <= 1'b0;
      log_scale_q       <= 1'b0;
      range_low_q       <= '0;
      range_high_q      <= RANGE_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (fvc_cfg_idx_e'(cfg_index_i))
        CFG_QUANTITY_SELECT: quantity_select_q <= fvc_qty_e'(cfg_data_i[1:0]);
        CFG_DIVERGING_MODE:  diverging_mode_q  <= cfg_data_i[0];
        CFG_LOG_SCALE:       log_scale_q       <= cfg_data_i[0];
        CFG_RANGE_LOW:       range_low_q       <= cfg_data_i;
        CFG_RANGE_HIGH:      range_high_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Values derived from the range registers.
  logic [31:0]         reach_q;
  logic [30:0]         top_q;
  logic [63:0]         prod_div_q;
  logic [62:0]         prod_nd_q;
  logic [31:0]         fl_div_q;
  logic [30:0]         fl_nd_q;
  logic [LOG_BITS-1:0] lreach_q, lfl_div_q, ltop_q, lfl_nd_q;
  logic signed [22:0]  span_div_q, span_nd_q;
  logic [31:0]         abs_lo, abs_hi;
  logic [31:0]         fl_div_raw;
  logic [30:0]         fl_nd_raw, fl_nd_d;

  assign abs_lo = range_low_q[VALUE_BITS-1] ? 32'(-range_low_q) : 32'(range_low_q);
  assign abs_hi = range_high_q[VALUE_BITS-1] ? 32'(-range_high_q) : 32'(range_high_q);
  assign fl_div_raw = 32'(prod_div_q >> RECIP_10K_SHIFT);
  assign fl_nd_raw = 31'(prod_nd_q >> RECIP_100K_SHIFT);

  always_comb begin
    fl_nd_d = (fl_nd_raw == '0) ? 31'd1 : fl_nd_raw;
    if (range_low_q > $signed({1'b0, fl_nd_d})) begin
      fl_nd_d = range_low_q[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    reach_q    <= (abs_lo > abs_hi) ? abs_lo : abs_hi;
    top_q      <= (range_high_q > 32'sd1) ? range_high_q[30:0] : 31'd1;
    prod_div_q <= reach_q * RECIP_10K;
    prod_nd_q  <= 63'(top_q * RECIP_100K);
    fl_div_q   <= (fl_div_raw == '0) ? 32'd1 : fl_div_raw;
    fl_nd_q    <= fl_nd_d;
    lreach_q   <= log2q({2'b00, reach_q});
    lfl_div_q  <= log2q({2'b00, fl_div_q});
    ltop_q     <= log2q({3'b000, top_q});
    lfl_nd_q   <= log2q({3'b000, fl_nd_q});
    span_div_q <= $signed({1'b0, lreach_q}) - $signed({1'b0, lfl_div_q});
    span_nd_q  <= $signed({1'b0, ltop_q}) - $signed({1'b0, lfl_nd_q});
  end

  // Stage enables: a stage loads when it is empty or the next one loads.
  always_comb begin : p_en
    logic rdy;
    rdy = !out_stall_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || rdy;
      rdy   = en[i];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= (i == 0) ? in_valid_i : vld_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Scalar selection and magnitude.
  fvc_in_t      in_q;
  logic [31:0]  ax, ay, az;
  logic         k_d;
  logic [30:0]  sx_q, sy_q, sz_q;
  fvc_sq_side_t s1_side_q, s2_side_q, s3_side_q, sq_side;
  fvc_sq_side_t s1_side_d;
  logic [61:0]  sqx_q, sqy_q, sqz_q;
  logic [63:0]  sum_q;
  logic [31:0]  root;

  assign ax = in_q.field_x[31] ? 32'(-in_q.field_x) : 32'(in_q.field_x);
  assign ay = in_q.field_y[31] ? 32'(-in_q.field_y) : 32'(in_q.field_y);
  assign az = in_q.field_z[31] ? 32'(-in_q.field_z) : 32'(in_q.field_z);
  assign k_d = ax[31] | ay[31] | az[31];

  always_comb begin
    s1_side_d.mag = (quantity_select_q == QTY_MAG);
    s1_side_d.k   = k_d;
    case (quantity_select_q)
      QTY_X:   s1_side_d.comp = 34'(in_q.field_x);
      QTY_Y:   s1_side_d.comp = 34'(in_q.field_y);
      QTY_Z:   s1_side_d.comp = 34'(in_q.field_z);
      default: s1_side_d.comp = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      in_q <= in_data_i;
    end
    if (en[1]) begin
      sx_q      <= k_d ? ax[31:1] : ax[30:0];
      sy_q      <= k_d ? ay[31:1] : ay[30:0];
      sz_q      <= k_d ? az[31:1] : az[30:0];
      s1_side_q <= s1_side_d;
    end
    if (en[2]) begin
      sqx_q     <= sx_q * sx_q;
      sqy_q     <= sy_q * sy_q;
      sqz_q     <= sz_q * sz_q;
      s2_side_q <= s1_side_q;
    end
    if (en[3]) begin
      sum_q     <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
      s3_side_q <= s2_side_q;
    end
  end

  fvc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en[SQ_HI:SQ_LO]),
    .rad_i  (sum_q),
    .side_i (s3_side_q),
    .root_o (root),
    .side_o (sq_side)
  );

  logic signed [33:0] v_q;

  always_ff @(posedge clk_i) begin
    if (en[V_ST]) begin
      if (sq_side.mag) begin
        v_q <= sq_side.k ? $signed({1'b0, root, 1'b0}) : $signed({2'b00, root});
      end else begin
        v_q <= sq_side.comp;
      end
    end
  end

  // Normalization setup.
  logic signed [33:0] lo34, hi34;
  logic [33:0]        av, mag_l, c_l;
  fvc_kind_e          kind_d, p_kind_q, z_kind_q, g_kind_d, g_kind_q;
  logic [33:0]        num_d, den_d, logx_d;
  logic [33:0]        p_num_q, p_den_q, p_logx_q, z_num_q, z_den_q, g_num_d, g_den_d;
  logic [33:0]        g_num_q, g_den_q;
  logic               p_neg_q, z_neg_q, g_neg_q;
  logic [5:0]         z_msb_q;
  logic [LOG_TABLE_BITS-1:0] z_idx_q;
  logic [LOG_BITS-1:0] lx, lfl;
  logic signed [22:0] num_l, span;

  assign lo34 = 34'(range_low_q);
  assign hi34 = 34'(range_high_q);
  assign av = v_q[33] ? 34'(-v_q) : 34'(v_q);
  assign mag_l = (av > {2'b00, fl_div_q}) ? av : {2'b00, fl_div_q};
  assign c_l = (v_q > $signed({3'b000, fl_nd_q})) ? 34'(v_q) : {3'b000, fl_nd_q};

  always_comb begin
    kind_d = KIND_ZERO;
    num_d  = 34'(v_q - lo34);
    den_d  = 34'(hi34 - lo34);
    logx_d = c_l;
    if (diverging_mode_q) begin
      if (reach_q == '0) begin
        kind_d = KIND_HALF;
      end else if (log_scale_q) begin
        logx_d = mag_l;
        kind_d = (mag_l >= {2'b00, reach_q}) ? KIND_ONE : KIND_LOG;
      end else begin
        num_d  = av;
        den_d  = {2'b00, reach_q};
        kind_d = (av >= {2'b00, reach_q}) ? KIND_ONE : KIND_DIV;
      end
    end else if (log_scale_q) begin
      if (span_nd_q <= 0) begin
        kind_d = KIND_ZERO;
      end else if (c_l >= {3'b000, top_q}) begin
        kind_d = KIND_ONE;
      end else begin
        kind_d = KIND_LOG;
      end
    end else begin
      if (hi34 <= lo34 || v_q <= lo34) begin
        kind_d = KIND_ZERO;
      end else if (v_q >= hi34) begin
        kind_d = KIND_ONE;
      end else begin
        kind_d = KIND_DIV;
      end
    end
  end

  assign lx = {z_msb_q, {FRAC_BITS{1'b0}}} + LOG_BITS'(LOG_TBL[z_idx_q]);
  assign lfl = diverging_mode_q ? lfl_div_q : lfl_nd_q;
  assign span = diverging_mode_q ? span_div_q : span_nd_q;
  assign num_l = $signed({1'b0, lx}) - $signed({1'b0, lfl});

  always_comb begin
    g_kind_d = z_kind_q;
    g_num_d  = z_num_q;
    g_den_d  = z_den_q;
    if (z_kind_q == KIND_LOG) begin
      g_num_d = 34'(unsigned'(num_l));
      g_den_d = 34'(unsigned'(span));
      if (span <= 0 || num_l <= 0) begin
        g_kind_d = KIND_ZERO;
      end else if (num_l >= span) begin
        g_kind_d = KIND_ONE;
      end else begin
        g_kind_d = KIND_DIV;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[PREP_ST]) begin
      p_kind_q <= kind_d;
      p_num_q  <= num_d;
      p_den_q  <= den_d;
      p_logx_q <= logx_d;
      p_neg_q  <= v_q[33];
    end
    if (en[LZ_ST]) begin
      z_msb_q  <= lead_one(p_logx_q);
      z_idx_q  <= log_idx(p_logx_q, lead_one(p_logx_q));
      z_kind_q <= p_kind_q;
      z_num_q  <= p_num_q;
      z_den_q  <= p_den_q;
      z_neg_q  <= p_neg_q;
    end
    if (en[LG_ST]) begin
      g_kind_q <= g_kind_d;
      g_num_q  <= g_num_d;
      g_den_q  <= g_den_d;
      g_neg_q  <= z_neg_q;
    end
  end

  logic [FRAC_BITS-1:0] quot;
  fvc_div_side_t        dv_side;

  fvc_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[DV_HI:DV_LO]),
    .num_i  (g_num_q),
    .den_i  (g_den_q),
    .side_i ('{kind: g_kind_q, neg: g_neg_q}),
    .quot_o (quot),
    .side_o (dv_side)
  );

  // Position on the ramp.
  logic [FRAC_BITS:0] q17, t_d, t_q;

  always_comb begin
    case (dv_side.kind)
      KIND_ONE: q17 = FRAC_ONE;
      KIND_DIV: q17 = {1'b0, quot};
      default:  q17 = '0;
    endcase
    if (!diverging_mode_q) begin
      t_d = q17;
    end else if (dv_side.kind == KIND_HALF) begin
      t_d = FRAC_HALF;
    end else if (dv_side.neg) begin
      t_d = FRAC_HALF - (q17 >> 1);
    end else begin
      t_d = FRAC_HALF + (q17 >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[T_ST]) begin
      t_q <= t_d;
    end
  end

  // Color interpolation.
  logic [19:0]          s5;
  logic [2:0]           low;
  logic [FRAC_BITS:0]   f_d, f_q;
  milli_t               a_d [3];
  milli_t               a_q [3];
  logic signed [10:0]   d_d [3];
  logic signed [10:0]   d_q [3];
  logic signed [29:0]   c_q [3];
  logic [21:0]          y_q [3];
  logic [COLOR_BITS-1:0] code_q [3];

  assign s5  = 20'(t_q) * 20'd5;
  assign low = (s5[18:16] > 3'd4) ? 3'd4 : s5[18:16];

  always_comb begin
    if (diverging_mode_q) begin
      if (t_q < FRAC_HALF) begin
        f_d = {t_q[FRAC_BITS-1:0], 1'b0};
      end else begin
        f_d = 17'({t_q - FRAC_HALF, 1'b0});
      end
    end else begin
      f_d = 17'(s5 - {1'b0, low, {FRAC_BITS{1'b0}}});
    end
    for (int i = 0; i < 3; i++) begin
      if (diverging_mode_q) begin
        a_d[i] = (t_q < FRAC_HALF) ? DIV_BLUE[i] : DIV_WHITE[i];
        d_d[i] = (t_q < FRAC_HALF) ?
                 $signed({1'b0, DIV_WHITE[i]}) - $signed({1'b0, DIV_BLUE[i]}) :
                 $signed({1'b0, DIV_RED[i]}) - $signed({1'b0, DIV_WHITE[i]});
      end else begin
        a_d[i] = VIRIDIS[low][i];
        d_d[i] = $signed({1'b0, VIRIDIS[3'(low + 3'd1)][i]}) -
                 $signed({1'b0, VIRIDIS[low][i]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (en[C1_ST]) begin
        a_q[i] <= a_d[i];
        d_q[i] <= d_d[i];
      end
      if (en[C2_ST]) begin
        c_q[i] <= 30'($signed({1'b0, a_q[i], {FRAC_BITS{1'b0}}})) +
                  30'($signed({1'b0, f_q}) * d_q[i]);
      end
      if (en[C3_ST]) begin
        y_q[i] <= 22'(((c_q[i] < 0 ? 38'd0 : 38'(c_q[i][28:0])) * 38'(CODE_MAX)
                       + CODE_ROUND) >> FRAC_BITS);
      end
      if (en[OUT_ST]) begin
        code_q[i] <= (43'(y_q[i]) * 43'(RECIP_1K) >> RECIP_1K_SHIFT) > 43'(CODE_MAX) ?
                     CODE_MAX :
                     COLOR_BITS'(43'(y_q[i]) * 43'(RECIP_1K) >> RECIP_1K_SHIFT);
      end
    end
    if (en[C1_ST]) begin
      f_q <= f_d;
    end
  end

  assign out_valid_o      = vld_q[OUT_ST];
  assign out_data_o.red   = code_q[0];
  assign out_data_o.green = code_q[1];
  assign out_data_o.blue  = code_q[2];

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> 32'($countones(vld_q)) ==
      32'($past($countones(vld_q))) + 32'($past(in_valid_i && !in_stall_o))
      - 32'($past(out_valid_o && !out_stall_i)))
    else $error("requests lost or duplicated in the pipeline");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[T_ST] |-> (t_q <= FRAC_ONE))
    else $error("normalized value out of range");

endmodule
